FILE: sv/serle_pkg.sv
package serle_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_ELEMENT_BYTES_DEF = 8;
	localparam int OFFSET_WIDTH_DEF      = 32;

	// Fixed field widths
	localparam int BYTE_W    = 8;
	localparam int EBYTES_W  = 4;
	localparam int STRIDE_W  = 16;
	localparam int SIZE_W    = 32;
	localparam int OFFSET_W  = 32;
	localparam int VALUE_W   = 64;
	localparam int COPIES_W  = 8;
	localparam int COUNT_W   = 32;
	localparam int BIDX_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	// copies times stride
	localparam int STEP_W    = COPIES_W + STRIDE_W;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_BYTES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_STRIDE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEST_SIZE      = 2'd2;

	// Decoder phase, one-hot
	typedef enum logic [2:0] {
		PH_HEADER  = 3'b001,
		PH_LITERAL = 3'b010,
		PH_REPEAT  = 3'b100
	} phase_t;

	// Current configuration
	typedef struct packed {
		logic [EBYTES_W-1:0] element_bytes;
		logic [STRIDE_W-1:0] element_stride;
		logic [SIZE_W-1:0]   dest_size;
	} cfg_t;

	// One write command
	typedef struct packed {
		logic [OFFSET_W-1:0] dest_offset;
		logic [VALUE_W-1:0]  element_value;
		logic [COPIES_W-1:0] copies;
		logic [COUNT_W-1:0]  source_used;
		logic                last;
	} res_t;

endpackage

FILE: sv/serle_cfg.sv
module serle_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [serle_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [serle_pkg::CFG_DATA_W-1:0]   cfg_data,
	output serle_pkg::cfg_t                    cfg,
	output logic [serle_pkg::STRIDE_W-1:0]     stride_nxt
);

	logic [serle_pkg::EBYTES_W-1:0] ebytes_q;
	logic [serle_pkg::STRIDE_W-1:0] stride_q;
	logic [serle_pkg::SIZE_W-1:0]   dsize_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ebytes_q <= serle_pkg::EBYTES_W'(1);
			stride_q <= serle_pkg::STRIDE_W'(1);
			dsize_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				serle_pkg::CFG_ELEMENT_BYTES:  ebytes_q <= cfg_data[serle_pkg::EBYTES_W-1:0];
				serle_pkg::CFG_ELEMENT_STRIDE: stride_q <= cfg_data[serle_pkg::STRIDE_W-1:0];
				serle_pkg::CFG_DEST_SIZE:      dsize_q  <= cfg_data[serle_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Stride as it will be after this edge, for the step precompute
	always_comb begin
		stride_nxt = stride_q;
		if (cfg_we && cfg_index == serle_pkg::CFG_ELEMENT_STRIDE)
			stride_nxt = cfg_data[serle_pkg::STRIDE_W-1:0];
	end

	assign cfg.element_bytes  = ebytes_q;
	assign cfg.element_stride = stride_q;
	assign cfg.dest_size      = dsize_q;

endmodule

FILE: sv/serle_core.sv
module serle_core #(
	parameter int MAX_ELEMENT_BYTES = serle_pkg::MAX_ELEMENT_BYTES_DEF,
	parameter int OFFSET_WIDTH      = serle_pkg::OFFSET_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            fire,
	input  logic [serle_pkg::BYTE_W-1:0]    byte_s1,
	input  serle_pkg::cfg_t                 cfg,
	input  logic [serle_pkg::STRIDE_W-1:0]  stride_nxt,
	output logic                            res_valid,
	output serle_pkg::res_t                 res
);

	localparam int BUF_W  = MAX_ELEMENT_BYTES * serle_pkg::BYTE_W;
	localparam int WIDE_W = (OFFSET_WIDTH > serle_pkg::STEP_W) ? OFFSET_WIDTH
		: serle_pkg::STEP_W;
	localparam int CMP_W  = ((WIDE_W > serle_pkg::SIZE_W) ? WIDE_W : serle_pkg::SIZE_W) + 1;

	serle_pkg::phase_t                phase_q, phase_d;
	logic [serle_pkg::COPIES_W-1:0]   run_q, run_d;
	logic [serle_pkg::BIDX_W-1:0]     bidx_q, bidx_d;
	logic [BUF_W-1:0]                 buf_q, buf_d, buf_new;
	logic [OFFSET_WIDTH-1:0]          off_q, off_d;
	logic [serle_pkg::COUNT_W-1:0]    cnt_q, cnt_d, cnt_inc;
	logic [serle_pkg::STEP_W-1:0]     step_q, step_d;
	logic [serle_pkg::COPIES_W-1:0]   copies_cur, copies_d;
	logic [serle_pkg::EBYTES_W-1:0]   eb_eff;
	logic                             elem_done;
	logic [CMP_W-1:0]                 off_ext, next_full;
	logic                             is_last;

	// Effective element size, clamped to 1..MAX
	always_comb begin
		eb_eff = cfg.element_bytes;
		if (cfg.element_bytes == '0)
			eb_eff = serle_pkg::EBYTES_W'(1);
		else if (cfg.element_bytes > serle_pkg::EBYTES_W'(MAX_ELEMENT_BYTES))
			eb_eff = serle_pkg::EBYTES_W'(MAX_ELEMENT_BYTES);
	end

	// Merge the incoming byte into its lane
	always_comb begin
		buf_new = buf_q;
		for (int i = 0; i < MAX_ELEMENT_BYTES; i++) begin
			if (bidx_q == serle_pkg::BIDX_W'(i))
				buf_new[i*serle_pkg::BYTE_W +: serle_pkg::BYTE_W] =
					buf_q[i*serle_pkg::BYTE_W +: serle_pkg::BYTE_W] | byte_s1;
		end
	end

	assign elem_done  = ({1'b0, bidx_q} + serle_pkg::EBYTES_W'(1)) >= eb_eff;
	assign copies_cur = (phase_q == serle_pkg::PH_REPEAT) ? run_q
		: serle_pkg::COPIES_W'(1);
	assign cnt_inc    = cnt_q + serle_pkg::COUNT_W'(1);

	// Offset after this command; step_q already holds copies * stride
	assign off_ext   = CMP_W'(off_q);
	assign next_full = off_ext + CMP_W'(step_q);
	assign is_last   = next_full >= CMP_W'(cfg.dest_size);

	// Next state
	always_comb begin
		phase_d   = phase_q;
		run_d     = run_q;
		bidx_d    = bidx_q;
		buf_d     = buf_q;
		off_d     = off_q;
		cnt_d     = cnt_q;
		res_valid = 1'b0;
		if (fire) begin
			cnt_d = cnt_inc;
			case (phase_q)
				serle_pkg::PH_LITERAL, serle_pkg::PH_REPEAT: begin
					if (!elem_done) begin
						bidx_d = bidx_q + serle_pkg::BIDX_W'(1);
						buf_d  = buf_new;
					end else begin
						res_valid = 1'b1;
						bidx_d    = '0;
						buf_d     = '0;
						if (is_last) begin
							// destination full: start a new decode
							phase_d = serle_pkg::PH_HEADER;
							run_d   = '0;
							off_d   = '0;
							cnt_d   = '0;
						end else begin
							off_d = next_full[OFFSET_WIDTH-1:0];
							if (phase_q == serle_pkg::PH_REPEAT) begin
								run_d   = '0;
								phase_d = serle_pkg::PH_HEADER;
							end else begin
								run_d = run_q - serle_pkg::COPIES_W'(1);
								if (run_q == serle_pkg::COPIES_W'(1))
									phase_d = serle_pkg::PH_HEADER;
							end
						end
					end
				end
				default: begin
					// header byte; unused codes land here too
					if (byte_s1[serle_pkg::BYTE_W-1]) begin
						run_d   = serle_pkg::COPIES_W'(9'd257 - {1'b0, byte_s1});
						phase_d = serle_pkg::PH_REPEAT;
					end else begin
						run_d   = byte_s1 + serle_pkg::COPIES_W'(1);
						phase_d = serle_pkg::PH_LITERAL;
					end
					bidx_d = '0;
					buf_d  = '0;
				end
			endcase
		end
	end

	// Offset step for the next element, from next state and next stride
	assign copies_d = (phase_d == serle_pkg::PH_REPEAT) ? run_d : serle_pkg::COPIES_W'(1);
	assign step_d   = serle_pkg::STEP_W'(copies_d) * serle_pkg::STEP_W'(stride_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= serle_pkg::PH_HEADER;
			run_q   <= '0;
			bidx_q  <= '0;
			buf_q   <= '0;
			off_q   <= '0;
			cnt_q   <= '0;
			step_q  <= serle_pkg::STEP_W'(1);
		end else begin
			phase_q <= phase_d;
			run_q   <= run_d;
			bidx_q  <= bidx_d;
			buf_q   <= buf_d;
			off_q   <= off_d;
			cnt_q   <= cnt_d;
			step_q  <= step_d;
		end
	end

	// Result fields
	assign res.dest_offset   = off_ext[serle_pkg::OFFSET_W-1:0];
	assign res.element_value = serle_pkg::VALUE_W'(buf_new);
	assign res.copies        = copies_cur;
	assign res.source_used   = cnt_inc;
	assign res.last          = is_last;

	// A run in progress always has elements left
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != serle_pkg::PH_HEADER) |-> (run_q != '0))
		else $error("run in progress with zero count");

	// Byte lane stays inside the element buffer
	a_bidx_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, bidx_q} < (serle_pkg::BIDX_W+1)'(MAX_ELEMENT_BYTES))
		else $error("byte index beyond element buffer");

	// Precomputed step tracks the live run and stride
	a_step_sync: assert property (@(posedge clk) disable iff (!arst_n)
		step_q == serle_pkg::STEP_W'(copies_cur) * serle_pkg::STEP_W'(cfg.element_stride))
		else $error("offset step out of sync");

	// A final command restarts the decode
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.last) |=>
		(off_q == '0 && cnt_q == '0 && phase_q == serle_pkg::PH_HEADER))
		else $error("decode did not restart after last command");

endmodule

FILE: sv/serle_out.sv
module serle_out (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  serle_pkg::res_t res,
	input  logic            dst_stall,
	output logic            out_free,
	output logic            dst_valid,
	output serle_pkg::res_t res_q
);

	logic valid_q;

	// Output register can take a new command when empty or being drained
	assign out_free = !valid_q || !dst_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load) begin
			res_q <= res;
		end
	end

	assign dst_valid = valid_q;

endmodule

FILE: sv/strided_element_rle_decoder.sv
// Channel   Direction  Handshake               Payload
// source    in         src_valid / src_stall   source_byte
// dest      out        dst_valid / dst_stall   dest_offset, element_value, copies,
//                                              source_used, last
// config    in         cfg_we                  cfg_index, cfg_data
//
// Sustains one source byte per cycle unless dst_stall holds a full output register;
// a command is decoded from its last byte in the input register into the output register.
// The copies * stride product is precomputed into a register, so the offset path is one add.
// Reset clears the decode state to expecting a header at offset 0, and the registers to
// element_bytes 1, element_stride 1, dest_size 0.
// dst_stall holding a full output register stalls the source in the same cycle
// while the input register holds a byte.
module strided_element_rle_decoder #(
	parameter int MAX_ELEMENT_BYTES = serle_pkg::MAX_ELEMENT_BYTES_DEF,
	parameter int OFFSET_WIDTH      = serle_pkg::OFFSET_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             src_valid,
	output logic                             src_stall,
	input  logic [serle_pkg::BYTE_W-1:0]     source_byte,
	output logic                             dst_valid,
	input  logic                             dst_stall,
	output logic [serle_pkg::OFFSET_W-1:0]   dest_offset,
	output logic [serle_pkg::VALUE_W-1:0]    element_value,
	output logic [serle_pkg::COPIES_W-1:0]   copies,
	output logic [serle_pkg::COUNT_W-1:0]    source_used,
	output logic                             last,
	input  logic                             cfg_we,
	input  logic [serle_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [serle_pkg::CFG_DATA_W-1:0] cfg_data
);

	serle_pkg::cfg_t                 cfg;
	logic [serle_pkg::STRIDE_W-1:0]  stride_nxt;
	logic                            valid_s1;
	logic [serle_pkg::BYTE_W-1:0]    byte_s1;
	logic                            out_free;
	logic                            fire;
	logic                            res_valid;
	serle_pkg::res_t                 res;
	serle_pkg::res_t                 res_q;

	serle_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cfg        (cfg),
		.stride_nxt (stride_nxt)
	);

	// Input register: the byte is decoded when the output side has room
	assign fire      = valid_s1 && out_free;
	assign src_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			byte_s1 <= source_byte;
		end
	end

	serle_core #(
		.MAX_ELEMENT_BYTES (MAX_ELEMENT_BYTES),
		.OFFSET_WIDTH      (OFFSET_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.byte_s1    (byte_s1),
		.cfg        (cfg),
		.stride_nxt (stride_nxt),
		.res_valid  (res_valid),
		.res        (res)
	);

	serle_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res       (res),
		.dst_stall (dst_stall),
		.out_free  (out_free),
		.dst_valid (dst_valid),
		.res_q     (res_q)
	);

	assign dest_offset   = res_q.dest_offset;
	assign element_value = res_q.element_value;
	assign copies        = res_q.copies;
	assign source_used   = res_q.source_used;
	assign last          = res_q.last;

endmodule
